// ----- rtl/ttce_pkg.sv -----
// ttce_pkg: shared types, operation and status codes, and small helpers
// for the truth table cube engine. No dependencies.

package ttce_pkg;

   localparam int AXIS_W  = 6;   // width of axis masks and cell indexes
   localparam int COUNT_W = 3;   // width of an axis count
   localparam int TABLE_W = 64;  // width of the packed table word

   // operation codes carried by req_kind
   localparam logic [2:0] KIND_INIT   = 3'd0;
   localparam logic [2:0] KIND_WRITE  = 3'd1;
   localparam logic [2:0] KIND_READ   = 3'd2;
   localparam logic [2:0] KIND_EXTEND = 3'd3;
   localparam logic [2:0] KIND_SLICE  = 3'd4;
   localparam logic [2:0] KIND_FOLD   = 3'd5;

   // response status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_AXIS   = 2'd1;
   localparam logic [1:0] STATUS_SHRINK = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   // sequencer commands into the index generator
   typedef struct packed {
      logic load;
      logic step;
   } sweep_ctrl_type;

   // index generator outputs
   typedef struct packed {
      logic [AXIS_W-1:0] addr;       // cell being visited (free | inner bits)
      logic [AXIS_W-1:0] k;          // packed result position
      logic              group_end;  // last inner cell of this result bit
      logic              last;       // last cell of the sweep
   } sweep_stat_type;

   // axes that exist for a table of n axes
   function automatic logic [AXIS_W-1:0] axis_range(input logic [COUNT_W-1:0] n);
      logic [AXIS_W:0] t;
      t = (7'd1 << n) - 7'd1;
      return t[AXIS_W-1:0];
   endfunction

   // next subset of sel in ascending packed order
   function automatic logic [AXIS_W-1:0] next_subset(input logic [AXIS_W-1:0] cur,
                                                     input logic [AXIS_W-1:0] sel);
      logic [AXIS_W-1:0] t;
      t = (cur | ~sel) + 6'd1;
      return t & sel;
   endfunction

   function automatic logic [COUNT_W-1:0] pop6(input logic [AXIS_W-1:0] v);
      logic [COUNT_W-1:0] c;
      c = '0;
      for (int j = 0; j < AXIS_W; j++) begin
         c = c + COUNT_W'(v[j]);
      end
      return c;
   endfunction

endpackage

// ----- rtl/truth_table_cube_engine_top.sv -----
// truth_table_cube_engine_top: truth table store with cube write, cell read,
// extend, slice and fold. Depends on ttce_pkg and ttce_idxgen.
//
// Usage:
//  - Command channel: drive req_* and raise start; the word is taken at a
//    clock edge with start high and busy low. Every word gives one response.
//  - Response: rsp_* carry the result for exactly one cycle while rsp_strobe
//    is high. The receiver cannot stall; it must take the word in that cycle.
//  - Sweeps: cell read, error cases, unused kinds and extend to the same
//    count answer without a sweep; init, cube write and extend visit all
//    2^MAX_AXES cells, slice 2^(free axes) cells, fold 2^(active axes) cells.
//  - The table is one rotating shift register; one cell is rewritten or
//    read per cycle, which sets all the sweep lengths above. Only one word
//    is in work at a time; busy is high for the whole sweep.
//  - A new word may be accepted in the same cycle the previous strobe shows.
//  - Reset (synchronous) clears the table, sets zero axes and drops busy.

module truth_table_cube_engine_top
   import ttce_pkg::*;
#(
   parameter int MAX_AXES = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_kind,
   input  logic [COUNT_W-1:0]   req_axis_count,
   input  logic [AXIS_W-1:0]    req_axis_mask,
   input  logic [AXIS_W-1:0]    req_axis_values,
   input  logic                 req_bit_value,
   output logic                 rsp_strobe,
   output logic                 rsp_cell_bit,
   output logic [TABLE_W-1:0]   rsp_table_bits,
   output logic [COUNT_W-1:0]   rsp_result_axes,
   output logic [1:0]           rsp_status
);

   localparam int CELLS  = 1 << MAX_AXES;
   localparam int ADDR_W = MAX_AXES;
   localparam int CNT_W  = MAX_AXES + 1;

   // control state
   state_type            state_ff, state_in;
   logic                 strobe_ff, strobe_in;
   logic [COUNT_W-1:0]   active_ff, active_in;
   logic [CELLS-1:0]     cell_ff, cell_in;     // the table, rotates during init, write and extend sweeps

   // operation held for the sweep
   logic [2:0]           kind_ff, kind_in;
   logic [AXIS_W-1:0]    mask_ff, mask_in;
   logic [AXIS_W-1:0]    vals_ff, vals_in;
   logic [AXIS_W-1:0]    fix_ff, fix_in;       // fixed address bits for slice
   logic                 bit_ff, bit_in;
   logic [COUNT_W-1:0]   nn_ff, nn_in;         // new axis count
   logic [COUNT_W-1:0]   old_n_ff, old_n_in;   // axis count at accept
   logic [AXIS_W-1:0]    free_sel_ff, free_sel_in;
   logic [AXIS_W-1:0]    inner_sel_ff, inner_sel_in;
   logic                 acc_ff, acc_in;
   logic [CELLS-1:0]     res_ff, res_in;       // slice / fold result

   // response fields
   logic                 rsp_cell_ff, rsp_cell_in;
   logic [COUNT_W-1:0]   rsp_axes_ff, rsp_axes_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic                 sel_res_ff, sel_res_in;

   sweep_ctrl_type       ctrl;
   sweep_stat_type       stat;

   logic                 accept;
   logic [COUNT_W-1:0]   req_nn;
   logic [AXIS_W-1:0]    cur_range;
   logic [AXIS_W-1:0]    req_freem;
   logic                 mask_bad;
   logic [AXIS_W-1:0]    rd_full;
   logic [ADDR_W-1:0]    rd_idx;
   logic                 rd_bit;
   logic [CNT_W-1:0]     ext_full;
   logic [ADDR_W-1:0]    ext_pos;
   logic                 in_old;     // sweep cell lies inside the old size
   logic                 in_new;     // sweep cell lies inside the new size
   logic                 hit;        // sweep cell matches the written cube
   logic                 top_bit;
   logic                 acc_new;

   ttce_idxgen u_idxgen (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .free_sel  (free_sel_ff),
      .inner_sel (inner_sel_ff),
      .stat      (stat)
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign req_nn    = (req_axis_count > COUNT_W'(MAX_AXES)) ? COUNT_W'(MAX_AXES)
                                                            : req_axis_count;
   assign cur_range = axis_range(active_ff);
   assign req_freem = cur_range & ~req_axis_mask;
   assign mask_bad  = (req_axis_mask & ~cur_range) != '0;

   // one cell read per cycle for slice and fold
   assign rd_full = stat.addr | fix_ff;
   assign rd_idx  = rd_full[ADDR_W-1:0];
   assign rd_bit  = cell_ff[rd_idx];

   // during extend, the new copy of cell i - 2^n sits at CELLS - 2^n
   assign ext_full = CNT_W'(CELLS) - (CNT_W'(1) << old_n_ff);
   assign ext_pos  = ext_full[ADDR_W-1:0];

   assign in_old  = (stat.addr & ~axis_range(old_n_ff)) == '0;
   assign in_new  = (stat.addr & ~axis_range(nn_ff)) == '0;
   assign hit     = in_old && (((stat.addr ^ vals_ff) & mask_ff) == '0);
   assign acc_new = bit_ff ? (acc_ff & rd_bit) : (acc_ff | rd_bit);

   always_comb begin
      case (kind_ff)
         KIND_INIT:   top_bit = bit_ff & in_new;
         KIND_WRITE:  top_bit = hit ? bit_ff : cell_ff[0];
         KIND_EXTEND: top_bit = in_old ? cell_ff[0] : (in_new & cell_ff[ext_pos]);
         default:     top_bit = cell_ff[0];
      endcase
   end

   // sequencer: next state, datapath loads and response set-up
   always_comb begin
      state_in      = state_ff;
      strobe_in     = 1'b0;
      active_in     = active_ff;
      cell_in       = cell_ff;
      kind_in       = kind_ff;
      mask_in       = mask_ff;
      vals_in       = vals_ff;
      fix_in        = fix_ff;
      bit_in        = bit_ff;
      nn_in         = nn_ff;
      old_n_in      = old_n_ff;
      free_sel_in   = free_sel_ff;
      inner_sel_in  = inner_sel_ff;
      acc_in        = acc_ff;
      res_in        = res_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_axes_in   = rsp_axes_ff;
      rsp_status_in = rsp_status_ff;
      sel_res_in    = sel_res_ff;
      ctrl          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in       = req_kind;
               mask_in       = req_axis_mask;
               vals_in       = req_axis_values;
               bit_in        = req_bit_value;
               nn_in         = req_nn;
               old_n_in      = active_ff;
               fix_in        = '0;
               acc_in        = req_bit_value;
               res_in        = '0;
               free_sel_in   = AXIS_W'(CELLS - 1);
               inner_sel_in  = '0;
               rsp_cell_in   = 1'b0;
               rsp_axes_in   = active_ff;
               rsp_status_in = STATUS_OK;
               sel_res_in    = 1'b0;
               state_in      = ST_IDLE;
               case (req_kind)
                  KIND_INIT: begin
                     active_in   = req_nn;
                     rsp_axes_in = req_nn;
                     state_in    = ST_SWEEP;
                  end
                  KIND_WRITE: begin
                     if (mask_bad) begin
                        rsp_status_in = STATUS_AXIS;
                     end else begin
                        state_in = ST_SWEEP;
                     end
                  end
                  KIND_READ: begin
                     if ((req_axis_values & ~cur_range) != '0) begin
                        rsp_status_in = STATUS_AXIS;
                     end else begin
                        rsp_cell_in = cell_ff[req_axis_values[ADDR_W-1:0]];
                     end
                  end
                  KIND_EXTEND: begin
                     if (req_nn < active_ff) begin
                        rsp_status_in = STATUS_SHRINK;
                     end else if (req_nn != active_ff) begin
                        active_in   = req_nn;
                        rsp_axes_in = req_nn;
                        state_in    = ST_SWEEP;
                     end
                  end
                  KIND_SLICE, KIND_FOLD: begin
                     if (mask_bad) begin
                        rsp_status_in = STATUS_AXIS;
                     end else begin
                        free_sel_in = req_freem;
                        rsp_axes_in = pop6(req_freem);
                        sel_res_in  = 1'b1;
                        state_in    = ST_SWEEP;
                        if (req_kind == KIND_FOLD) begin
                           inner_sel_in = req_axis_mask;
                        end else begin
                           fix_in = req_axis_values & req_axis_mask;
                        end
                     end
                  end
                  default: ;
               endcase
               if (state_in == ST_SWEEP) begin
                  ctrl.load = 1'b1;
               end else begin
                  strobe_in = 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            ctrl.step = 1'b1;
            case (kind_ff)
               KIND_SLICE: begin
                  res_in[stat.k[ADDR_W-1:0]] = rd_bit;
               end
               KIND_FOLD: begin
                  if (stat.group_end) begin
                     res_in[stat.k[ADDR_W-1:0]] = acc_new;
                     acc_in = bit_ff;
                  end else begin
                     acc_in = acc_new;
                  end
               end
               default: begin
                  cell_in = {top_bit, cell_ff[CELLS-1:1]};
               end
            endcase
            if (stat.last) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         active_ff <= '0;
         cell_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         active_ff <= active_in;
         cell_ff   <= cell_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      mask_ff       <= mask_in;
      vals_ff       <= vals_in;
      fix_ff        <= fix_in;
      bit_ff        <= bit_in;
      nn_ff         <= nn_in;
      old_n_ff      <= old_n_in;
      free_sel_ff   <= free_sel_in;
      inner_sel_ff  <= inner_sel_in;
      acc_ff        <= acc_in;
      res_ff        <= res_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_axes_ff   <= rsp_axes_in;
      rsp_status_ff <= rsp_status_in;
      sel_res_ff    <= sel_res_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_cell_bit    = rsp_cell_ff;
   assign rsp_table_bits  = sel_res_ff ? TABLE_W'(res_ff) : TABLE_W'(cell_ff);
   assign rsp_result_axes = rsp_axes_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTH
   // a response only shows once the sweep is over
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE))
      else $error("response strobe during sweep");

   // every accepted word either sweeps or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted word neither swept nor answered");

   // cells past the active size stay zero between operations
   a_cells_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((TABLE_W'(cell_ff) >> (7'd1 << active_ff)) == '0))
      else $error("cell set beyond active size");

   // a failed word reports no cell bit
   a_error_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> !rsp_cell_bit)
      else $error("cell bit set on error response");
`endif

endmodule

// ----- rtl/ttce_idxgen.sv -----
// ttce_idxgen: walks cell indexes for a sweep as two nested subset counters
// (outer over free axes, inner over folded axes). Depends on ttce_pkg.

module ttce_idxgen
   import ttce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  sweep_ctrl_type       ctrl,
   input  logic [AXIS_W-1:0]    free_sel,
   input  logic [AXIS_W-1:0]    inner_sel,
   output sweep_stat_type       stat
);

   logic [AXIS_W-1:0] free_ff, free_in;
   logic [AXIS_W-1:0] dep_ff, dep_in;
   logic [AXIS_W-1:0] k_ff, k_in;
   logic              group_end;

   assign group_end      = (dep_ff == inner_sel);
   assign stat.addr      = free_ff | dep_ff;
   assign stat.k         = k_ff;
   assign stat.group_end = group_end;
   assign stat.last      = group_end && (free_ff == free_sel);

   always_comb begin
      free_in = free_ff;
      dep_in  = dep_ff;
      k_in    = k_ff;
      if (ctrl.load) begin
         free_in = '0;
         dep_in  = '0;
         k_in    = '0;
      end else if (ctrl.step) begin
         if (group_end) begin
            dep_in  = '0;
            free_in = next_subset(free_ff, free_sel);
            k_in    = k_ff + 6'd1;
         end else begin
            dep_in = next_subset(dep_ff, inner_sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
         dep_ff  <= '0;
         k_ff    <= '0;
      end else begin
         free_ff <= free_in;
         dep_ff  <= dep_in;
         k_ff    <= k_in;
      end
   end

endmodule
